/* hdl/rcw_pkg.sv */
// shared types and constants for the raycast wall column setup block
// no dependencies; used by the front, queue, back and top-level modules
`default_nettype none

package rcw_pkg;

  localparam int DIST_W = 24;
  localparam int DIR_W = 18;
  localparam int POS_W = 24;
  localparam int POS_LO_W = 16;
  localparam int FRAC_W = 32;
  localparam int LH_W = 16;
  localparam int ROW_W = 9;
  localparam int FACE_W = 2;
  localparam int COL_W = 6;

  localparam int IN_TDATA_W = 112;
  localparam int OUT_TDATA_W = 48;

  localparam int SCREEN_ROWS_DEF = 512;
  localparam int TEXTURE_COLUMNS_DEF = 64;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [FACE_W-1:0] {
    FACE_EAST  = 2'd0,
    FACE_WEST  = 2'd1,
    FACE_SOUTH = 2'd2,
    FACE_NORTH = 2'd3
  } face_t;

  // classified column, handed from the front to the back through the queue
  typedef struct packed {
    logic [DIST_W-1:0]       distance;
    logic signed [DIR_W-1:0] dir;
    logic [POS_LO_W-1:0]     pos_lo;
    logic                    shade;
    face_t                   face;
    logic                    mirror;
    logic                    sat;
  } cls_t;

endpackage

`default_nettype wire

/* hdl/rcw_front.sv */
// front end: accepts input transactions and classifies the hit
// (face, mirroring, coordinate select, height saturation); uses rcw_pkg
`default_nettype none

module rcw_front #(
  parameter int SCREEN_ROWS = rcw_pkg::SCREEN_ROWS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [rcw_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                          in_tuser,
  input  wire logic                          q_full,
  output logic                               q_push,
  output rcw_pkg::cls_t                      q_item
);

  logic [rcw_pkg::DIST_W-1:0]       distance;
  logic signed [rcw_pkg::DIR_W-1:0] dx;
  logic signed [rcw_pkg::DIR_W-1:0] dy;
  logic [rcw_pkg::POS_W-1:0]        px;
  logic [rcw_pkg::POS_W-1:0]        py;
  logic                             horiz;
  logic                             seen_r;

  assign distance = in_tdata[23:0];
  assign dx       = $signed(in_tdata[41:24]);
  assign dy       = $signed(in_tdata[59:42]);
  assign px       = in_tdata[83:60];
  assign py       = in_tdata[107:84];
  assign horiz    = in_tuser;

  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

  always_comb begin
    q_item.distance = distance;
    q_item.shade    = horiz;
    // quotient only reaches 2^16 when the distance is at most the row count
    q_item.sat      = (distance == '0) || (distance <= rcw_pkg::DIST_W'(SCREEN_ROWS));
    if (!horiz) begin
      q_item.face   = (dx > 0) ? rcw_pkg::FACE_EAST : rcw_pkg::FACE_WEST;
      q_item.mirror = (dx > 0);
      q_item.dir    = dy;
      q_item.pos_lo = py[rcw_pkg::POS_LO_W-1:0];
    end else begin
      q_item.face   = (dy > 0) ? rcw_pkg::FACE_SOUTH : rcw_pkg::FACE_NORTH;
      q_item.mirror = (dy < 0);
      q_item.dir    = dx;
      q_item.pos_lo = px[rcw_pkg::POS_LO_W-1:0];
    end
  end

  // marks that at least one transaction has gone in since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (q_push) begin
      seen_r <= 1'b1;
    end
  end

`ifndef SYNTH
  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_tready && !q_full && in_tvalid))
    else $error("front pushed into a full queue");
  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |=> seen_r)
    else $error("front seen flag dropped");
  a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && (distance == '0)) |-> q_item.sat)
    else $error("zero distance not flagged for saturation");
`endif

endmodule

`default_nettype wire

/* hdl/rcw_queue.sv */
// short queue of classified columns between front and back
// uses rcw_pkg::cls_t and rcw_pkg::QUEUE_DEPTH
`default_nettype none

module rcw_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rcw_pkg::cls_t din,
  output logic               full,
  input  wire logic          pop,
  output logic               avail,
  output rcw_pkg::cls_t      dout
);

  localparam int DEPTH = rcw_pkg::QUEUE_DEPTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rcw_pkg::cls_t  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign avail   = (cnt_r != '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & avail;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");
  a_avail_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> avail)
    else $error("queue empty right after a push");
`endif

endmodule

`default_nettype wire

/* hdl/rcw_back.sv */
// back end: 16-stage pipelined restoring divider for the line height,
// hit fraction multiply and texture column, row clamping; uses rcw_pkg
`default_nettype none

module rcw_back #(
  parameter int SCREEN_ROWS     = rcw_pkg::SCREEN_ROWS_DEF,
  parameter int TEXTURE_COLUMNS = rcw_pkg::TEXTURE_COLUMNS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            head_valid,
  input  wire rcw_pkg::cls_t                   head,
  output logic                                 pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [rcw_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tuser
);

  localparam int NST = rcw_pkg::LH_W;
  localparam int TCW = $clog2(TEXTURE_COLUMNS + 1);
  localparam int HALF_ROWS = SCREEN_ROWS / 2;
  localparam int DW = rcw_pkg::DIST_W;
  localparam int FW = rcw_pkg::FRAC_W;

  typedef struct packed {
    logic [DW-1:0]                distance;
    logic [DW-1:0]                rem;
    logic [rcw_pkg::LH_W-1:0]     quo;
    logic                         sat;
    rcw_pkg::face_t               face;
    logic                         mirror;
    logic                         shade;
    logic [rcw_pkg::POS_LO_W-1:0] pos_lo;
    logic [FW-1:0]                prod;
    logic [FW-1:0]                frac;
    logic [TCW-1:0]               col;
  } stage_t;

  stage_t            head_st;
  stage_t            src [NST];
  stage_t            st_nxt [NST];
  stage_t            st_r [NST];
  logic [NST-1:0]    vld_r;
  logic              adv;
  logic              out_tvalid_r;
  logic [rcw_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic              out_tuser_r;

  logic [rcw_pkg::LH_W-1:0]   lh;
  logic [rcw_pkg::LH_W-2:0]   half;
  logic [rcw_pkg::LH_W-1:0]   first_full;
  logic [rcw_pkg::LH_W:0]     last_sum;
  logic [rcw_pkg::LH_W:0]     last_full;
  logic [TCW+rcw_pkg::COL_W-1:0] col_ext;
  logic signed [DW+rcw_pkg::DIR_W:0] head_prod;

  // whole pipeline moves when the output register is free or being taken
  assign adv = ~out_tvalid_r | out_tready;
  assign pop = adv & head_valid;

  assign head_prod = $signed({1'b0, head.distance}) * $signed(head.dir);

  always_comb begin
    head_st          = '0;
    head_st.distance = head.distance;
    head_st.rem      = DW'(SCREEN_ROWS);
    head_st.sat      = head.sat;
    head_st.face     = head.face;
    head_st.mirror   = head.mirror;
    head_st.shade    = head.shade;
    head_st.pos_lo   = head.pos_lo;
    // only the low 32 bits of the product reach the fraction
    head_st.prod     = head_prod[FW-1:0];
  end

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_src
      if (k == 0) begin : g_head
        assign src[k] = head_st;
      end else begin : g_prev
        assign src[k] = st_r[k-1];
      end
    end

    for (k = 0; k < NST; k++) begin : g_stage
      logic [DW:0]        shl;
      logic               ge;
      logic [FW+TCW-1:0]  cprod;
      logic [TCW-1:0]     colraw;

      always_comb begin
        st_nxt[k] = src[k];
        shl = {src[k].rem, 1'b0};
        ge  = (shl >= {1'b0, src[k].distance});
        st_nxt[k].rem = ge ? DW'(shl - {1'b0, src[k].distance}) : shl[DW-1:0];
        st_nxt[k].quo = {src[k].quo[rcw_pkg::LH_W-2:0], ge};
        cprod  = {{TCW{1'b0}}, src[k].frac} * (FW+TCW)'(TEXTURE_COLUMNS);
        colraw = cprod[FW +: TCW];
        if (k == 1) begin
          st_nxt[k].frac = src[k].prod + {src[k].pos_lo, 16'b0};
        end
        if (k == 2) begin
          st_nxt[k].col = src[k].mirror ? TCW'(TEXTURE_COLUMNS - 1) - colraw : colraw;
        end
      end
    end
  endgenerate

  always_comb begin
    lh = st_r[NST-1].sat ? '1 : st_r[NST-1].quo;
    half = lh[rcw_pkg::LH_W-1:1];
    first_full = ({1'b0, half} >= rcw_pkg::LH_W'(HALF_ROWS)) ? '0 :
                 rcw_pkg::LH_W'(HALF_ROWS) - {1'b0, half};
    last_sum  = {2'b0, half} + (rcw_pkg::LH_W+1)'(HALF_ROWS);
    last_full = (last_sum >= (rcw_pkg::LH_W+1)'(SCREEN_ROWS)) ?
                (rcw_pkg::LH_W+1)'(SCREEN_ROWS - 1) : last_sum;
    col_ext = {{rcw_pkg::COL_W{1'b0}}, st_r[NST-1].col};
    out_tdata_nxt = {6'b0, col_ext[rcw_pkg::COL_W-1:0], st_r[NST-1].face,
                     last_full[rcw_pkg::ROW_W-1:0], first_full[rcw_pkg::ROW_W-1:0], lh};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      vld_r        <= {vld_r[NST-2:0], head_valid};
      out_tvalid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NST; i++) begin
        st_r[i] <= st_nxt[i];
      end
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= st_r[NST-1].shade;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTH
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valids moved during a stall");
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[NST-1]) |=> out_tvalid)
    else $error("finished column lost before output register");
  a_pop_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> vld_r[0])
    else $error("popped column did not enter the divider");
`endif

endmodule

`default_nettype wire

/* hdl/raycast_wall_column_setup.sv */
// Raycast wall column setup. Each input transaction carries one screen column's
// ray hit; each output transaction gives line height, first/last row, face,
// texture column and shade. Columns stream at one per clock: the front
// classifies the hit and drops it into a two-entry queue, the back runs a
// 16-stage pipelined restoring divider (one quotient bit per stage) beside the
// hit-fraction multiply, then an output register. Throughput is one column per cycle,
// set by the divider pipeline, and any downstream stall holds the whole back pipeline.
// uses rcw_pkg, rcw_front, rcw_queue, rcw_back
`default_nettype none

module raycast_wall_column_setup #(
  parameter int SCREEN_ROWS     = rcw_pkg::SCREEN_ROWS_DEF,
  parameter int TEXTURE_COLUMNS = rcw_pkg::TEXTURE_COLUMNS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // wall_distance, dir_x, dir_y, player_x, player_y, zero fill
  input  wire logic [rcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // hit_horizontal
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // line_height, first_row, last_row, face, texture_column, zero fill
  output logic [rcw_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // shade
  output logic                                 out_tuser
);

  logic          q_full;
  logic          q_push;
  rcw_pkg::cls_t q_in;
  logic          q_pop;
  logic          q_avail;
  rcw_pkg::cls_t q_out;

  rcw_front #(
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  rcw_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_in),
    .full (q_full),
    .pop  (q_pop),
    .avail(q_avail),
    .dout (q_out)
  );

  rcw_back #(
    .SCREEN_ROWS    (SCREEN_ROWS),
    .TEXTURE_COLUMNS(TEXTURE_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_avail),
    .head      (q_out),
    .pop       (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

/* tb/wall_stripe_checker.sv */
// wall stripe checker: watches both stream channels of the raycast column setup block,
// predicts each column's stripe and compares it field by field in order of arrival
// depends on rcw_pkg for field widths, screen/texture sizes and the face encoding
`timescale 1ns / 1ps

module wall_stripe_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  // wall_distance, dir_x, dir_y, player_x, player_y, zero fill
  input  wire logic [rcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // hit_horizontal
  input  wire logic                            in_tuser,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  // line_height, first_row, last_row, face, texture_column, zero fill
  input  wire logic [rcw_pkg::OUT_TDATA_W-1:0] out_tdata,
  // shade
  input  wire logic                            out_tuser,
  output int                                   mismatches,
  output int                                   pending,
  output int                                   checked
);

  localparam int SCREEN_ROWS = rcw_pkg::SCREEN_ROWS_DEF;
  localparam int TEXTURE_COLUMNS = rcw_pkg::TEXTURE_COLUMNS_DEF;

  localparam int DX_LO = rcw_pkg::DIST_W;
  localparam int DY_LO = DX_LO + rcw_pkg::DIR_W;
  localparam int PX_LO = DY_LO + rcw_pkg::DIR_W;
  localparam int PY_LO = PX_LO + rcw_pkg::POS_W;

  localparam int FR_LO = rcw_pkg::LH_W;
  localparam int LR_LO = FR_LO + rcw_pkg::ROW_W;
  localparam int FACE_LO = LR_LO + rcw_pkg::ROW_W;
  localparam int COL_LO = FACE_LO + rcw_pkg::FACE_W;

  typedef struct packed {
    logic [rcw_pkg::LH_W-1:0]  stripe_rows;
    logic [rcw_pkg::ROW_W-1:0] first_row;
    logic [rcw_pkg::ROW_W-1:0] last_row;
    rcw_pkg::face_t            face;
    logic [rcw_pkg::COL_W-1:0] texture_column;
    logic                      shade;
  } stripe_t;

  stripe_t expected_stripes[$];

  // fraction of the exact hit coordinate scaled to texels; the hit wraps mod 2^64
  function automatic logic [rcw_pkg::COL_W-1:0] texel_column(
      input logic [rcw_pkg::POS_W-1:0] pos,
      input logic signed [rcw_pkg::DIR_W-1:0] dir,
      input logic [rcw_pkg::DIST_W-1:0] distance);
    logic [63:0] hit;
    logic [63:0] scaled;
    hit = ({40'b0, pos} << 16) + 64'(longint'(distance) * longint'(dir));
    scaled = {32'b0, hit[31:0]} * 64'(TEXTURE_COLUMNS);
    return scaled[32 +: rcw_pkg::COL_W];
  endfunction

  function automatic stripe_t predict_stripe(input logic [rcw_pkg::IN_TDATA_W-1:0] d,
                                             input logic horiz);
    stripe_t s;
    logic [rcw_pkg::DIST_W-1:0] distance;
    logic signed [rcw_pkg::DIR_W-1:0] dx;
    logic signed [rcw_pkg::DIR_W-1:0] dy;
    logic [rcw_pkg::POS_W-1:0] px;
    logic [rcw_pkg::POS_W-1:0] py;
    longint unsigned height;
    longint unsigned half;
    longint unsigned bottom;
    logic [rcw_pkg::COL_W-1:0] col;
    logic mirror;
    distance = d[0 +: rcw_pkg::DIST_W];
    dx = d[DX_LO +: rcw_pkg::DIR_W];
    dy = d[DY_LO +: rcw_pkg::DIR_W];
    px = d[PX_LO +: rcw_pkg::POS_W];
    py = d[PY_LO +: rcw_pkg::POS_W];

    if (distance == 0) begin
      height = 65535;
    end else begin
      height = (longint'(SCREEN_ROWS) << 16) / longint'(distance);
      if (height > 65535) height = 65535;
    end
    half = height / 2;
    s.stripe_rows = height[rcw_pkg::LH_W-1:0];
    if (half >= SCREEN_ROWS / 2) s.first_row = '0;
    else s.first_row = rcw_pkg::ROW_W'(SCREEN_ROWS / 2 - half);
    bottom = half + SCREEN_ROWS / 2;
    if (bottom >= SCREEN_ROWS) bottom = SCREEN_ROWS - 1;
    s.last_row = bottom[rcw_pkg::ROW_W-1:0];

    // vertical hits take y of the hit point, horizontal ones take x
    if (!horiz) begin
      s.face = (dx > 0) ? rcw_pkg::FACE_EAST : rcw_pkg::FACE_WEST;
      col = texel_column(py, dy, distance);
      mirror = dx > 0;
    end else begin
      s.face = (dy > 0) ? rcw_pkg::FACE_SOUTH : rcw_pkg::FACE_NORTH;
      col = texel_column(px, dx, distance);
      mirror = dy < 0;
    end
    if (mirror) col = rcw_pkg::COL_W'(TEXTURE_COLUMNS - 1 - int'(col));
    s.texture_column = col;
    s.shade = horiz;
    return s;
  endfunction

  task automatic flag_field(input string name, input longint want, input longint got,
                            inout int bad);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      bad++;
    end
  endtask

  always @(posedge clk) begin : watch
    stripe_t got;
    stripe_t want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      mismatches <= 0;
      pending <= 0;
      checked <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_stripes.push_back(predict_stripe(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        got.stripe_rows = out_tdata[0 +: rcw_pkg::LH_W];
        got.first_row = out_tdata[FR_LO +: rcw_pkg::ROW_W];
        got.last_row = out_tdata[LR_LO +: rcw_pkg::ROW_W];
        got.face = rcw_pkg::face_t'(out_tdata[FACE_LO +: rcw_pkg::FACE_W]);
        got.texture_column = out_tdata[COL_LO +: rcw_pkg::COL_W];
        got.shade = out_tuser;
        if (expected_stripes.size() == 0) begin
          $display("%0t: unexpected stripe transaction, expected none got %h / %b",
                   $time, out_tdata, out_tuser);
          bad++;
        end else begin
          want = expected_stripes.pop_front();
          if ($isunknown({out_tdata, out_tuser})) begin
            $display("%0t: stripe expected %h got unknown bits %h / %b",
                     $time, want, out_tdata, out_tuser);
            bad++;
          end else begin
            flag_field("stripe_rows", want.stripe_rows, got.stripe_rows, bad);
            flag_field("first_row", want.first_row, got.first_row, bad);
            flag_field("last_row", want.last_row, got.last_row, bad);
            flag_field("face", want.face, got.face, bad);
            flag_field("texture_column", want.texture_column, got.texture_column, bad);
            flag_field("shade", want.shade, got.shade, bad);
          end
          checked <= checked + 1;
        end
      end
      mismatches <= mismatches + bad;
      pending <= expected_stripes.size();
    end
  end

endmodule

/* tb/raycast_wall_column_setup_tb.sv */
// top of the raycast wall column setup testbench: clock, reset, column stimulus and verdict
// depends on rcw_pkg, raycast_wall_column_setup and wall_stripe_checker
`timescale 1ns / 1ps

module raycast_wall_column_setup_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 375;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [rcw_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [rcw_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;

  int mismatches;
  int pending;
  int checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int columns_sent = 0;
  int directed_sent = 0;
  int cycles = 0;

  always #1 clk = ~clk;

  raycast_wall_column_setup u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  wall_stripe_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d stripes outstanding", cycles, pending);
      $display("raycast_wall_column_setup_tb: errors");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_column(input logic [23:0] wall_dist, input logic [17:0] dx,
                             input logic [17:0] dy, input logic [23:0] px,
                             input logic [23:0] py, input logic horiz);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, py, px, dy, dx, wall_dist};
    in_tuser <= horiz;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    columns_sent++;
    @(negedge clk);
  endtask

  // hold the sender off until every stripe in flight has come out
  task automatic drain_stripes();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [17:0] pick_direction();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
      2: return 18'($urandom_range(0, 511)) - 18'd256;
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_position();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int idle_mix[4];
    int stall_mix[4];
    logic [23:0] wall_dist;
    idle_mix = '{0, 45, 0, 33};
    stall_mix = '{0, 0, 45, 33};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero and tiny distances up to the row count saturate the height, one just above it does not
    send_column(24'h000000, 18'h10000, 18'h08000, 24'h012345, 24'h034567, 1'b0);
    send_column(24'h000001, 18'h1FFFF, 18'h20000, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_column(24'h000200, 18'h00001, 18'h3FFFF, 24'h000000, 24'h000000, 1'b1);
    send_column(24'h000201, 18'h3FFFF, 18'h00001, 24'h00FFFF, 24'hFF0000, 1'b1);
    // stripe exactly filling the screen and just inside it
    send_column(24'h010000, 18'h0C000, 18'h04000, 24'h028000, 24'h014000, 1'b0);
    send_column(24'h00FFFF, 18'h04000, 18'h3C000, 24'h020000, 24'h030000, 1'b1);
    send_column(24'h010001, 18'h02000, 18'h02000, 24'h011111, 24'h022222, 1'b0);
    send_column(24'h020000, 18'h3E000, 18'h06000, 24'h050000, 24'h060000, 1'b1);
    send_column(24'hFFFFFF, 18'h20000, 18'h1FFFF, 24'h000000, 24'h000000, 1'b1);
    send_column(24'hFFFFFF, 18'h1FFFF, 18'h20000, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    // vertical hit with zero and negative dir_x faces west unmirrored
    send_column(24'h018000, 18'h00000, 18'h0C000, 24'h028000, 24'h014000, 1'b0);
    send_column(24'h018000, 18'h3F000, 18'h3F000, 24'h028000, 24'h014000, 1'b0);
    // horizontal hit with zero dir_y faces north unmirrored, negative mirrors
    send_column(24'h020000, 18'h08000, 18'h00000, 24'h043210, 24'h012345, 1'b1);
    send_column(24'h018000, 18'h0C000, 18'h38000, 24'h043210, 24'h012345, 1'b1);
    send_column(24'h018000, 18'h3C000, 18'h20000, 24'h000001, 24'h7FFFFF, 1'b1);
    send_column(24'h030000, 18'h00000, 18'h00000, 24'h800000, 24'h800000, 1'b0);
    send_column(24'h030000, 18'h00000, 18'h00000, 24'h800000, 24'h800000, 1'b1);
    send_column(24'h123456, 18'h2AAAA, 18'h15555, 24'hAAAAAA, 24'h555555, 1'b0);
    send_column(24'h654321, 18'h15555, 18'h2AAAA, 24'h555555, 24'hAAAAAA, 1'b1);
    directed_sent = columns_sent;

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = idle_mix[phase];
      stall_pct = stall_mix[phase];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        case ($urandom_range(0, 9))
          0, 1: wall_dist = 24'($urandom_range(1, 1023));
          2, 3: wall_dist = 24'($urandom_range(32'h8000, 32'h30000));
          4, 5, 6: wall_dist = 24'($urandom_range(32'h30000, 32'h400000));
          7: wall_dist = 24'($urandom_range(32'hF00000, 32'hFFFFFF));
          default: wall_dist = 24'($urandom);
        endcase
        send_column(wall_dist, pick_direction(), pick_direction(), pick_position(),
                    pick_position(), 1'($urandom_range(0, 1)));
      end
      drain_stripes();
    end

    repeat (40) @(negedge clk);
    $display("sent %0d columns (%0d directed) through four sender/receiver idle mixes",
             columns_sent, directed_sent);
    $display("%0d stripes compared, %0d field mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("raycast_wall_column_setup_tb: clean");
    end else begin
      $display("raycast_wall_column_setup_tb: errors");
    end
    $finish;
  end

endmodule

/* raycast_wall_column_setup.f */
hdl/rcw_pkg.sv
hdl/rcw_front.sv
hdl/rcw_queue.sv
hdl/rcw_back.sv
hdl/raycast_wall_column_setup.sv
tb/wall_stripe_checker.sv
tb/raycast_wall_column_setup_tb.sv
